>>> src/m4t_pkg.sv
package m4t_pkg;

  localparam int DATA_W = 32;
  localparam int MAT_N = 4;
  localparam int IDX_W = 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PROD_W = 2 * DATA_W;

  localparam logic [1:0] FUNC_WR_A = 2'd0;
  localparam logic [1:0] FUNC_WR_B = 2'd1;
  localparam logic [1:0] FUNC_POINT = 2'd2;
  localparam logic [1:0] FUNC_PROD = 2'd3;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_PROD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } lane_ctl_t;

  typedef struct packed {
    logic             load;
    logic             kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } emit_ctl_t;

endpackage

>>> src/m4t_lane.sv
module m4t_lane #(
  parameter int FRAC_BITS = m4t_pkg::FRAC_BITS_DEF,
  parameter int ACC_W = m4t_pkg::PROD_W - FRAC_BITS + 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  m4t_pkg::lane_ctl_t                  ctl,
  input  logic signed [m4t_pkg::DATA_W-1:0]   a_op,
  input  logic signed [m4t_pkg::DATA_W-1:0]   b_op,
  input  logic signed [m4t_pkg::DATA_W-1:0]   bias,
  output logic signed [ACC_W-1:0]             acc
);

  localparam int PW = m4t_pkg::PROD_W;
  localparam int TW = PW - FRAC_BITS;

  logic signed [PW-1:0] prod;
  logic signed [TW-1:0] term;

  assign term = prod[PW-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PW'(a_op) * PW'(b_op);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.clear) begin
      acc <= {{(ACC_W - m4t_pkg::DATA_W){bias[m4t_pkg::DATA_W-1]}}, bias};
    end else if (ctl.acc_en) begin
      acc <= acc + {{(ACC_W - TW){term[TW-1]}}, term};
    end
  end

endmodule

>>> src/m4t_merge.sv
module m4t_merge #(
  parameter int ACC_W = 51
) (
  input  logic                               clk,
  input  logic                               rst,
  input  m4t_pkg::emit_ctl_t                 ctl,
  input  logic signed [ACC_W-1:0]            acc [m4t_pkg::MAT_N],
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic                               kind,
  output logic signed [m4t_pkg::DATA_W-1:0]  out_x,
  output logic signed [m4t_pkg::DATA_W-1:0]  out_y,
  output logic signed [m4t_pkg::DATA_W-1:0]  out_z,
  output logic [m4t_pkg::IDX_W-1:0]          prod_row,
  output logic [m4t_pkg::IDX_W-1:0]          prod_col,
  output logic signed [m4t_pkg::DATA_W-1:0]  prod_value,
  output logic                               last
);

  localparam int DW = m4t_pkg::DATA_W;
  localparam logic signed [ACC_W-1:0] MAXV = {{(ACC_W - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MINV = {{(ACC_W - DW + 1){1'b1}}, {(DW - 1){1'b0}}};

  logic signed [DW-1:0] sat [m4t_pkg::MAT_N];

  for (genvar i = 0; i < m4t_pkg::MAT_N; i++) begin : g_sat
    always_comb begin
      if (acc[i] > MAXV) begin
        sat[i] = {1'b0, {(DW - 1){1'b1}}};
      end else if (acc[i] < MINV) begin
        sat[i] = {1'b1, {(DW - 1){1'b0}}};
      end else begin
        sat[i] = acc[i][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      kind <= ctl.kind;
      last <= ctl.last;
      if (ctl.kind == m4t_pkg::KIND_PROD) begin
        out_x      <= '0;
        out_y      <= '0;
        out_z      <= '0;
        prod_row   <= ctl.row;
        prod_col   <= ctl.col;
        prod_value <= sat[ctl.row];
      end else begin
        out_x      <= sat[0];
        out_y      <= sat[1];
        out_z      <= sat[2];
        prod_row   <= '0;
        prod_col   <= '0;
        prod_value <= '0;
      end
    end
  end

endmodule

>>> src/matrix4_transform_unit.sv
// Holds two 4x4 Q16.16 matrices A and B, both cleared by reset. func 0 and 1 write
// one entry of A or B. func 2 transforms (x,y,z) by A as an affine map with w=1 and
// gives one result: four row lanes each run one registered multiplier over three
// steps, then drain and saturate. func 3 streams the 16 entries of A x B, column by
// column with rows inner, last marked on the final one: each column takes 4 multiply
// steps, a drain step and 4 output transfers. Products are floored after the
// FRAC_BITS shift; each sum saturates once to 32 bits. A new item is taken only when
// the previous one has finished loading its results into the output register.
module matrix4_transform_unit #(
  parameter int FRAC_BITS = m4t_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         func,
  input  logic [m4t_pkg::IDX_W-1:0]          row_sel,
  input  logic [m4t_pkg::IDX_W-1:0]          col_sel,
  input  logic signed [m4t_pkg::DATA_W-1:0]  entry_in,
  input  logic signed [m4t_pkg::DATA_W-1:0]  point_x,
  input  logic signed [m4t_pkg::DATA_W-1:0]  point_y,
  input  logic signed [m4t_pkg::DATA_W-1:0]  point_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               kind,
  output logic signed [m4t_pkg::DATA_W-1:0]  out_x,
  output logic signed [m4t_pkg::DATA_W-1:0]  out_y,
  output logic signed [m4t_pkg::DATA_W-1:0]  out_z,
  output logic [m4t_pkg::IDX_W-1:0]          prod_row,
  output logic [m4t_pkg::IDX_W-1:0]          prod_col,
  output logic signed [m4t_pkg::DATA_W-1:0]  prod_value,
  output logic                               last
);

  localparam int DW = m4t_pkg::DATA_W;
  localparam int N = m4t_pkg::MAT_N;
  localparam int IW = m4t_pkg::IDX_W;
  localparam int ACC_W = m4t_pkg::PROD_W - FRAC_BITS + 3;

  logic signed [DW-1:0] mat_a [N][N];
  logic signed [DW-1:0] mat_b [N][N];
  logic signed [DW-1:0] pt [3];

  m4t_pkg::state_t state, state_next;
  logic [IW-1:0] kcnt, kcnt_next;
  logic [IW-1:0] col, col_next;
  logic [IW-1:0] row, row_next;
  logic mode_prod, mode_prod_next;

  logic in_fire;
  logic bias_en;
  logic k_done;
  logic signed [DW-1:0] b_op;
  logic signed [ACC_W-1:0] acc [N];
  m4t_pkg::lane_ctl_t lane_ctl;
  m4t_pkg::emit_ctl_t emit_ctl;

  assign in_stall = rst || (state != m4t_pkg::ST_IDLE);
  assign in_fire = in_valid && !in_stall;
  assign k_done = mode_prod ? (kcnt == IW'(N - 1)) : (kcnt == IW'(N - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < N; r++) begin
        for (int c = 0; c < N; c++) begin
          mat_a[r][c] <= '0;
          mat_b[r][c] <= '0;
        end
      end
    end else if (in_fire && func == m4t_pkg::FUNC_WR_A) begin
      mat_a[row_sel][col_sel] <= entry_in;
    end else if (in_fire && func == m4t_pkg::FUNC_WR_B) begin
      mat_b[row_sel][col_sel] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && func == m4t_pkg::FUNC_POINT) begin
      pt[0] <= point_x;
      pt[1] <= point_y;
      pt[2] <= point_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= m4t_pkg::ST_IDLE;
      kcnt      <= '0;
      col       <= '0;
      row       <= '0;
      mode_prod <= 1'b0;
    end else begin
      state     <= state_next;
      kcnt      <= kcnt_next;
      col       <= col_next;
      row       <= row_next;
      mode_prod <= mode_prod_next;
    end
  end

  always_comb begin
    state_next     = state;
    kcnt_next      = kcnt;
    col_next       = col;
    row_next       = row;
    mode_prod_next = mode_prod;
    lane_ctl       = '0;
    emit_ctl       = '0;
    bias_en        = 1'b0;
    emit_ctl.kind  = mode_prod ? m4t_pkg::KIND_PROD : m4t_pkg::KIND_POINT;
    emit_ctl.row   = row;
    emit_ctl.col   = col;
    emit_ctl.last  = !mode_prod || (row == IW'(N - 1) && col == IW'(N - 1));
    case (state)
      m4t_pkg::ST_IDLE: begin
        if (in_fire && (func == m4t_pkg::FUNC_POINT || func == m4t_pkg::FUNC_PROD)) begin
          mode_prod_next = (func == m4t_pkg::FUNC_PROD);
          bias_en        = (func == m4t_pkg::FUNC_POINT);
          lane_ctl.clear = 1'b1;
          kcnt_next      = '0;
          col_next       = '0;
          row_next       = '0;
          state_next     = m4t_pkg::ST_MAC;
        end
      end
      m4t_pkg::ST_MAC: begin
        lane_ctl.mul_en = 1'b1;
        lane_ctl.acc_en = (kcnt != '0);
        kcnt_next       = kcnt + 1'b1;
        if (k_done) begin
          state_next = m4t_pkg::ST_DRAIN;
        end
      end
      m4t_pkg::ST_DRAIN: begin
        lane_ctl.acc_en = 1'b1;
        state_next      = m4t_pkg::ST_EMIT;
      end
      m4t_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          emit_ctl.load = 1'b1;
          if (!mode_prod) begin
            state_next = m4t_pkg::ST_IDLE;
          end else if (row == IW'(N - 1)) begin
            row_next = '0;
            if (col == IW'(N - 1)) begin
              state_next = m4t_pkg::ST_IDLE;
            end else begin
              col_next       = col + 1'b1;
              kcnt_next      = '0;
              lane_ctl.clear = 1'b1;
              state_next     = m4t_pkg::ST_MAC;
            end
          end else begin
            row_next = row + 1'b1;
          end
        end
      end
      default: begin
        state_next = m4t_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (mode_prod) begin
      b_op = mat_b[kcnt][col];
    end else begin
      case (kcnt)
        2'd0:    b_op = pt[0];
        2'd1:    b_op = pt[1];
        2'd2:    b_op = pt[2];
        default: b_op = '0;
      endcase
    end
  end

  for (genvar r = 0; r < N; r++) begin : g_lane
    m4t_lane #(
      .FRAC_BITS(FRAC_BITS),
      .ACC_W(ACC_W)
    ) u_lane (
      .clk (clk),
      .rst (rst),
      .ctl (lane_ctl),
      .a_op(mat_a[r][kcnt]),
      .b_op(b_op),
      .bias(bias_en ? mat_a[r][N-1] : '0),
      .acc (acc[r])
    );
  end

  m4t_merge #(
    .ACC_W(ACC_W)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctl       (emit_ctl),
    .acc       (acc),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .kind      (kind),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .prod_row  (prod_row),
    .prod_col  (prod_col),
    .prod_value(prod_value),
    .last      (last)
  );

  a_prod_last_corner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == m4t_pkg::KIND_PROD && last) |->
      (prod_row == IW'(N - 1) && prod_col == IW'(N - 1)))
    else $error("last product transfer not at the final corner");

  a_point_always_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == m4t_pkg::KIND_POINT) |-> last)
    else $error("point result without last");

  a_point_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == m4t_pkg::ST_MAC && !mode_prod) |-> (kcnt != IW'(N - 1)))
    else $error("point transform stepped onto the bias column");

  a_start_mac: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (func == m4t_pkg::FUNC_POINT || func == m4t_pkg::FUNC_PROD)) |=>
      (state == m4t_pkg::ST_MAC && kcnt == '0))
    else $error("compute item did not start the multiply steps");

endmodule
